[hw/rtl/ggb_pkg.sv]
// ----------------------------------------------------------------------------
// ggb_pkg
// Shared types, constants and kernel weights for the gray 5x5 Gaussian blur.
// ----------------------------------------------------------------------------
package ggb_pkg;

    localparam int unsigned GRAY_W   = 8;
    localparam int unsigned ROW_W    = 3;
    localparam int unsigned SUM_W    = 17;
    localparam int unsigned WT_W     = 6;
    localparam int unsigned ACC_A_W  = 13;   // 17 * 255
    localparam int unsigned ACC_BC_W = 15;   // 107 * 255
    localparam int unsigned PIX_W    = 10;   // r + g + b
    localparam int unsigned PROD_W   = 21;
    localparam int unsigned RECIP_W  = 11;
    localparam int unsigned NCOL     = 5;

    localparam logic [ROW_W-1:0]   ROW_FIRST = 3'd0;
    localparam logic [ROW_W-1:0]   ROW_LAST  = 3'd4;

    // x / 3 == (x * 683) >> 11 for every x up to 765
    localparam logic [RECIP_W-1:0] RECIP_3     = 11'd683;
    localparam int unsigned        RECIP_SHIFT = 11;

    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic [ROW_W-1:0]  row;
    } t_item;

    // weights of the two outer kernel columns
    function automatic logic [WT_W-1:0] f_wt_outer(input logic [ROW_W-1:0] row);
        logic [WT_W-1:0] w;
        case (row)
            3'd0:    w = 6'd1;
            3'd1:    w = 6'd4;
            3'd2:    w = 6'd7;
            3'd3:    w = 6'd4;
            3'd4:    w = 6'd1;
            default: w = 6'd0;
        endcase
        return w;
    endfunction

    // weights of the two columns next to the center
    function automatic logic [WT_W-1:0] f_wt_inner(input logic [ROW_W-1:0] row);
        logic [WT_W-1:0] w;
        case (row)
            3'd0:    w = 6'd4;
            3'd1:    w = 6'd16;
            3'd2:    w = 6'd26;
            3'd3:    w = 6'd16;
            3'd4:    w = 6'd4;
            default: w = 6'd0;
        endcase
        return w;
    endfunction

    // weights of the center column
    function automatic logic [WT_W-1:0] f_wt_center(input logic [ROW_W-1:0] row);
        logic [WT_W-1:0] w;
        case (row)
            3'd0:    w = 6'd7;
            3'd1:    w = 6'd26;
            3'd2:    w = 6'd41;
            3'd3:    w = 6'd26;
            3'd4:    w = 6'd7;
            default: w = 6'd0;
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/ggb_front.sv]
// ----------------------------------------------------------------------------
// ggb_front
// Accepts pixels, converts them to gray and tags each with its row index.
// ----------------------------------------------------------------------------
module ggb_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [ggb_pkg::GRAY_W-1:0]  i_red,
    input  logic [ggb_pkg::GRAY_W-1:0]  i_green,
    input  logic [ggb_pkg::GRAY_W-1:0]  i_blue,
    input  logic                        i_q_ready,
    output logic                        o_push,
    output ggb_pkg::t_item              o_item
);
    import ggb_pkg::*;

    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  n_row;
    logic [PIX_W-1:0]  w_pix_sum;
    logic [PROD_W-1:0] w_prod;

    assign o_push = i_valid & i_q_ready;

    assign w_pix_sum = PIX_W'(i_red) + PIX_W'(i_green) + PIX_W'(i_blue);
    assign w_prod    = PROD_W'(w_pix_sum) * PROD_W'(RECIP_3);

    assign o_item.gray = w_prod[RECIP_SHIFT +: GRAY_W];
    assign o_item.row  = r_row;

    always_comb begin
        n_row = r_row;
        if (o_push) begin
            n_row = (r_row == ROW_LAST) ? ROW_FIRST : r_row + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= ROW_FIRST;
        end else begin
            r_row <= n_row;
        end
    end

endmodule

[hw/rtl/ggb_fifo.sv]
// ----------------------------------------------------------------------------
// ggb_fifo
// Two-entry queue between the pixel front end and the column back end.
// ----------------------------------------------------------------------------
module ggb_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ggb_pkg::t_item  i_item,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output ggb_pkg::t_item  o_item
);
    import ggb_pkg::*;

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= n_count;
        end
    end

endmodule

[hw/rtl/ggb_back.sv]
// ----------------------------------------------------------------------------
// ggb_back
// Builds per-column weighted sums, keeps five columns of history and
// emits the kernel sum at the end of each column.
// ----------------------------------------------------------------------------
module ggb_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  ggb_pkg::t_item              i_item,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ggb_pkg::SUM_W-1:0]   o_blurred_sum
);
    import ggb_pkg::*;

    // per-column dot products with the outer, inner and center weight columns
    logic [ACC_A_W-1:0]  r_acc_a;
    logic [ACC_BC_W-1:0] r_acc_b;
    logic [ACC_BC_W-1:0] r_acc_c;
    logic [ACC_A_W-1:0]  r_hist_a [NCOL];
    logic [ACC_BC_W-1:0] r_hist_b [NCOL];
    logic [ACC_BC_W-1:0] r_hist_c [NCOL];
    logic                r_out_valid;
    logic [SUM_W-1:0]    r_out_sum;

    logic                w_last;
    logic                w_first;
    logic [ACC_A_W-1:0]  w_term_a;
    logic [ACC_BC_W-1:0] w_term_b;
    logic [ACC_BC_W-1:0] w_term_c;
    logic [ACC_A_W-1:0]  w_col_a;
    logic [ACC_BC_W-1:0] w_col_b;
    logic [ACC_BC_W-1:0] w_col_c;
    logic [SUM_W-1:0]    w_sum;

    assign w_last  = (i_item.row == ROW_LAST);
    assign w_first = (i_item.row == ROW_FIRST);
    assign o_pop   = i_q_valid & (!w_last | !r_out_valid | i_ready);

    assign w_term_a = ACC_A_W'(i_item.gray) * ACC_A_W'(f_wt_outer(i_item.row));
    assign w_term_b = ACC_BC_W'(i_item.gray) * ACC_BC_W'(f_wt_inner(i_item.row));
    assign w_term_c = ACC_BC_W'(i_item.gray) * ACC_BC_W'(f_wt_center(i_item.row));

    assign w_col_a = (w_first ? '0 : r_acc_a) + w_term_a;
    assign w_col_b = (w_first ? '0 : r_acc_b) + w_term_b;
    assign w_col_c = (w_first ? '0 : r_acc_c) + w_term_c;

    // kernel columns mirror around the center
    assign w_sum = SUM_W'(r_hist_a[0]) + SUM_W'(r_hist_b[1]) + SUM_W'(r_hist_c[2])
                 + SUM_W'(r_hist_b[3]) + SUM_W'(r_hist_a[4]);

    assign o_valid       = r_out_valid;
    assign o_blurred_sum = r_out_sum;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_acc_a <= w_col_a;
            r_acc_b <= w_col_b;
            r_acc_c <= w_col_c;
        end
        if (o_pop && w_last) begin
            r_out_sum <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int k = 0; k < NCOL; k++) begin
                r_hist_a[k] <= '0;
                r_hist_b[k] <= '0;
                r_hist_c[k] <= '0;
            end
        end else begin
            if (o_pop && w_last) begin
                r_out_valid <= 1'b1;
                for (int k = NCOL - 1; k > 0; k--) begin
                    r_hist_a[k] <= r_hist_a[k-1];
                    r_hist_b[k] <= r_hist_b[k-1];
                    r_hist_c[k] <= r_hist_c[k-1];
                end
                r_hist_a[0] <= w_col_a;
                r_hist_b[0] <= w_col_b;
                r_hist_c[0] <= w_col_c;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[hw/rtl/gray_gaussian_blur_5x5_top.sv]
// ----------------------------------------------------------------------------
// gray_gaussian_blur_5x5_top
// Gray conversion of RGB pixels and 5x5 Gaussian weighted sum per column.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------
//   pixel    | in        | i_valid / o_ready  | i_red, i_green, i_blue
//   result   | out       | o_valid / i_ready  | o_blurred_sum
//
// one pixel per cycle sustained while results are taken; one result per five pixels.
// the column's fifth pixel is written into the queue, and o_valid is registered when the back end pops it.
// a two-entry queue sits between front and back; o_ready drops only when it is full.
// a held result stalls only fifth-row pixels; other rows keep draining the queue.
// after reset the window is zero, so the first result is zero.
// ----------------------------------------------------------------------------
module gray_gaussian_blur_5x5_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ggb_pkg::GRAY_W-1:0]  i_red,
    input  logic [ggb_pkg::GRAY_W-1:0]  i_green,
    input  logic [ggb_pkg::GRAY_W-1:0]  i_blue,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ggb_pkg::SUM_W-1:0]   o_blurred_sum
);
    import ggb_pkg::*;

    logic  w_push;
    logic  w_pop;
    logic  w_q_ready;
    logic  w_q_valid;
    t_item w_front_item;
    t_item w_back_item;

    assign o_ready = w_q_ready;

    ggb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_red     (i_red),
        .i_green   (i_green),
        .i_blue    (i_blue),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_item    (w_front_item)
    );

    ggb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_back_item)
    );

    ggb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_item        (w_back_item),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_blurred_sum (o_blurred_sum)
    );

endmodule

[hw/rtl/ggb_chk.sv]
// ----------------------------------------------------------------------------
// ggb_chk
// Port-level checks for the gray 5x5 Gaussian blur, bound to the top level.
// ----------------------------------------------------------------------------
module ggb_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_ready,
    input  logic                        o_valid,
    input  logic                        i_ready,
    input  logic [ggb_pkg::SUM_W-1:0]   o_blurred_sum
);
    import ggb_pkg::*;

    localparam logic [SUM_W-1:0] SUM_MAX = 17'd69615;

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_blurred_sum))
        else $error("result dropped or changed while stalled");

    a_sum_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_blurred_sum <= SUM_MAX)
        else $error("weighted sum above kernel maximum");

    a_no_result_after_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_ready_after_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("pixel channel not ready after reset");

    // the fifth pixel either passed through the queue as a transaction or sat behind a full queue
    a_no_result_without_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 2) || $past(!o_ready, 2))
        else $error("result appeared without pending pixels");

endmodule

bind gray_gaussian_blur_5x5_top ggb_chk u_ggb_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_blurred_sum (o_blurred_sum)
);

[test/gray_gaussian_blur_5x5_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gray_gaussian_blur_5x5_top_tb
// Streams RGB pixels into the gray 5x5 blur and checks every column sum against
// a behavioral window model, with random idle bursts on both handshakes.
// ----------------------------------------------------------------------------
module gray_gaussian_blur_5x5_top_tb;

    import ggb_pkg::*;

    localparam int unsigned DIR_N          = 25;
    localparam int unsigned RAND_COLS      = 140;
    localparam int unsigned QUIET_COLS     = 20;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned WIN_DIM        = 5;
    localparam logic [SUM_W-1:0] MAX_SUM   = 17'd69615;

    typedef struct packed {
        logic [GRAY_W-1:0] red;
        logic [GRAY_W-1:0] green;
        logic [GRAY_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        t_pixel           pixel;
        logic             typed;
        logic [SUM_W-1:0] sum;
    } t_dir_row;

    typedef enum logic [1:0] {
        COL_RANDOM,
        COL_WHITE,
        COL_BLACK,
        COL_EDGE
    } t_col_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [GRAY_W-1:0]  i_red;
    logic [GRAY_W-1:0]  i_green;
    logic [GRAY_W-1:0]  i_blue;
    logic               o_valid;
    logic               i_ready;
    logic [SUM_W-1:0]   o_blurred_sum;

    // window model: entry WIN_DIM*c + r is row r of column c, column 0 newest
    logic [GRAY_W-1:0]  gray_win [WIN_DIM*WIN_DIM];
    logic [ROW_W-1:0]   row_pos;
    logic [SUM_W-1:0]   latched_sum;

    logic [SUM_W-1:0]   blur_sum_q [$];
    logic [SUM_W-1:0]   exp_sum;

    bit                 idle_en;
    int unsigned        ready_hold;
    int unsigned        quiet_cycles;
    int unsigned        err_count;
    int unsigned        pixels_sent;
    int unsigned        sums_checked;
    int unsigned        max_sums;
    int unsigned        zero_sums;

    t_dir_row dir_table [DIR_N] = '{
        // first column after reset sees an empty window
        {8'd255, 8'd255, 8'd255, 1'b0, 17'd0},
        {8'd255, 8'd255, 8'd255, 1'b0, 17'd0},
        {8'd255, 8'd255, 8'd255, 1'b0, 17'd0},
        {8'd255, 8'd255, 8'd255, 1'b0, 17'd0},
        {8'd255, 8'd255, 8'd255, 1'b1, 17'd0},
        // truncation of the divide by three
        {8'd1,   8'd0,   8'd0,   1'b0, 17'd0},
        {8'd0,   8'd1,   8'd1,   1'b0, 17'd0},
        {8'd255, 8'd255, 8'd254, 1'b0, 17'd0},
        {8'd0,   8'd0,   8'd0,   1'b0, 17'd0},
        {8'd128, 8'd64,  8'd32,  1'b0, 17'd0},
        {8'd255, 8'd0,   8'd0,   1'b0, 17'd0},
        {8'd0,   8'd255, 8'd0,   1'b0, 17'd0},
        {8'd0,   8'd0,   8'd255, 1'b0, 17'd0},
        {8'd170, 8'd85,  8'd85,  1'b0, 17'd0},
        {8'd3,   8'd3,   8'd3,   1'b0, 17'd0},
        {8'd85,  8'd170, 8'd255, 1'b0, 17'd0},
        {8'd2,   8'd0,   8'd0,   1'b0, 17'd0},
        {8'd0,   8'd2,   8'd2,   1'b0, 17'd0},
        {8'd254, 8'd255, 8'd255, 1'b0, 17'd0},
        {8'd15,  8'd240, 8'd90,  1'b0, 17'd0},
        {8'd0,   8'd0,   8'd0,   1'b0, 17'd0},
        {8'd255, 8'd255, 8'd255, 1'b0, 17'd0},
        {8'd0,   8'd0,   8'd0,   1'b0, 17'd0},
        {8'd255, 8'd255, 8'd255, 1'b0, 17'd0},
        {8'd1,   8'd1,   8'd1,   1'b0, 17'd0}
    };

    gray_gaussian_blur_5x5_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_blurred_sum (o_blurred_sum)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // kernel weight from the distance to the window center
    function automatic int unsigned blur_weight(input int unsigned row, input int unsigned col);
        int unsigned dr;
        int unsigned dc;
        int unsigned near;
        int unsigned far;
        dr   = (row > 2) ? row - 2 : 2 - row;
        dc   = (col > 2) ? col - 2 : 2 - col;
        near = (dr < dc) ? dr : dc;
        far  = (dr < dc) ? dc : dr;
        case ({near[1:0], far[1:0]})
            4'b0000: return 41;
            4'b0001: return 26;
            4'b0010: return 7;
            4'b0101: return 16;
            4'b0110: return 4;
            default: return 1;
        endcase
    endfunction

    task automatic blur_predict(input t_pixel px, output logic has_sum,
                                output logic [SUM_W-1:0] sum);
        logic [PIX_W-1:0] total;
        logic [ROW_W-1:0] row;
        int unsigned      acc;
        int               k;
        row = (row_pos > ROW_LAST) ? ROW_FIRST : row_pos;
        if (row == ROW_FIRST) begin
            acc = 0;
            for (k = 0; k < WIN_DIM*WIN_DIM; k++) begin
                acc += gray_win[k] * blur_weight(k % WIN_DIM, k / WIN_DIM);
            end
            latched_sum = acc[SUM_W-1:0];
            for (k = WIN_DIM*WIN_DIM - 1; k >= WIN_DIM; k--) begin
                gray_win[k] = gray_win[k - WIN_DIM];
            end
        end
        total = px.red + px.green + px.blue;
        gray_win[row] = GRAY_W'(total / 3);
        has_sum = (row == ROW_LAST);
        sum     = latched_sum;
        row_pos = has_sum ? ROW_FIRST : row + 1'b1;
    endtask

    function automatic logic [GRAY_W-1:0] edge_level();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd2;
            3:       return 8'd253;
            4:       return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    function automatic t_pixel make_pixel(input t_col_mode mode);
        t_pixel px;
        case (mode)
            COL_WHITE: px = '{red: 8'd255, green: 8'd255, blue: 8'd255};
            COL_BLACK: px = '{red: 8'd0, green: 8'd0, blue: 8'd0};
            COL_EDGE:  px = '{red: edge_level(), green: edge_level(), blue: edge_level()};
            default:   px = '{red: GRAY_W'($urandom_range(0, 255)),
                              green: GRAY_W'($urandom_range(0, 255)),
                              blue: GRAY_W'($urandom_range(0, 255))};
        endcase
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // one pixel transaction; typed_sum overrides the model where the table gives it
    task automatic send_pixel(input t_pixel px, input logic typed, input logic [SUM_W-1:0] typed_sum);
        logic             has_sum;
        logic [SUM_W-1:0] sum;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red   <= px.red;
        i_green <= px.green;
        i_blue  <= px.blue;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        blur_predict(px, has_sum, sum);
        if (has_sum) begin
            blur_sum_q.push_back(typed ? typed_sum : sum);
        end
        pixels_sent++;
    endtask

    // result side stalls in bursts
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (idle_en && $urandom_range(0, 6) == 0) begin
            ready_hold <= $urandom_range(0, 4);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (blur_sum_q.size() == 0) begin
                report_mismatch($sformatf("result %0d with none pending", o_blurred_sum));
            end else begin
                exp_sum = blur_sum_q.pop_front();
                if (o_blurred_sum !== exp_sum) begin
                    report_mismatch($sformatf("blurred_sum %0d, want %0d", o_blurred_sum,
                                              exp_sum));
                end
                if (exp_sum == MAX_SUM) max_sums++;
                if (exp_sum == '0) zero_sums++;
                sums_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles", $realtime, quiet_cycles);
            $display("** gray_gaussian_blur_5x5_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_col_mode   mode;
        int unsigned run_left;
        int unsigned col;
        int unsigned row;
        int unsigned i;

        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_red        <= '0;
        i_green      <= '0;
        i_blue       <= '0;
        i_ready      <= 1'b0;
        ready_hold   = 0;
        quiet_cycles = 0;
        err_count    = 0;
        pixels_sent  = 0;
        sums_checked = 0;
        max_sums     = 0;
        zero_sums    = 0;
        idle_en      = 1'b0;
        run_left     = 0;
        mode         = COL_RANDOM;
        for (i = 0; i < WIN_DIM*WIN_DIM; i++) gray_win[i] = '0;
        row_pos     = ROW_FIRST;
        latched_sum = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_en = 1'b1;

        for (i = 0; i < DIR_N; i++) begin
            send_pixel(dir_table[i].pixel, dir_table[i].typed, dir_table[i].sum);
        end

        // runs of like columns so saturated and empty windows build up
        for (col = 0; col < RAND_COLS; col++) begin
            if (run_left == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: mode = COL_WHITE;
                    3:       mode = COL_BLACK;
                    4, 5:    mode = COL_EDGE;
                    default: mode = COL_RANDOM;
                endcase
                run_left = $urandom_range(1, 7);
            end
            run_left--;
            idle_en = (col < RAND_COLS - QUIET_COLS) && ((col / 12) % 3 != 2);
            for (row = 0; row < WIN_DIM; row++) begin
                send_pixel(make_pixel(mode), 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        while (blur_sum_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d pixels, checked %0d column sums", pixels_sent, sums_checked);
        $display("saturated window sums: %0d, zero sums: %0d", max_sums, zero_sums);
        if (err_count == 0) begin
            $display("** gray_gaussian_blur_5x5_top: PASSED **");
        end else begin
            $display("** gray_gaussian_blur_5x5_top: FAILED **");
        end
        $finish;
    end

endmodule
